/* hdl/imh_pkg.sv */
// ----------------------------------------------------------------------------
// imh_pkg: shared types for the indexed two-key min-heap
// Operation codes, datapath micro-commands, controller states, status bundle and heap entry.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int OP_W   = 3;
  localparam int ID_W   = 8;
  localparam int KEY_W  = 32;
  localparam int CNT_W  = 16;
  localparam int SIZE_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_DELMIN = 3'd2,
    OP_CHANGE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    UC_NONE,
    UC_LATCH,
    UC_ERR,
    UC_INS,
    UC_REM_RD,
    UC_REM,
    UC_CHG_RD,
    UC_CHG,
    UC_CLEAR,
    UC_RISE_RD,
    UC_RISE_STEP,
    UC_SINK_RD,
    UC_SINK_STEP,
    UC_PLACE,
    UC_OUT
  } ucode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_REM,
    S_CHG,
    S_RISE,
    S_RISE_CMP,
    S_SINK,
    S_SINK_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic req_valid;
    op_t  op;
    logic id_ok;
    logic present;
    logic full;
    logic empty;
    logic rem_same;
    logic rem_rise;
    logic chg_up;
    logic chg_down;
    logic rise_more;
    logic parent_greater;
    logic sink_has;
    logic sink_move;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } entry_t;

endpackage

/* hdl/imh_req_if.sv */
// ----------------------------------------------------------------------------
// imh_req_if: request channel
// Valid/ready channel carrying one heap operation.
// ----------------------------------------------------------------------------
interface imh_req_if;
  logic                              valid;
  logic                              ready;
  logic [imh_pkg::OP_W-1:0]          operation;
  logic [imh_pkg::ID_W-1:0]          item_id;
  logic signed [imh_pkg::KEY_W-1:0]  key_value;
  logic [imh_pkg::CNT_W-1:0]         count_value;

  modport source (output valid, operation, item_id, key_value, count_value, input ready);
  modport sink (input valid, operation, item_id, key_value, count_value, output ready);
endinterface

/* hdl/imh_rsp_if.sv */
// ----------------------------------------------------------------------------
// imh_rsp_if: response channel
// Valid/ready channel carrying the result of one heap operation.
// ----------------------------------------------------------------------------
interface imh_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [imh_pkg::ID_W-1:0]    min_item;
  logic [imh_pkg::SIZE_W-1:0]  heap_size;
  logic                        error;

  modport source (output valid, min_item, heap_size, error, input ready);
  modport sink (input valid, min_item, heap_size, error, output ready);
endinterface

/* hdl/indexed_min_heap_two_key_core.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_two_key_core: indexed binary min-heap with two-part keys
// Insert, remove by id, delete-minimum, change-key and clear over ids
// 1..MAX_ITEMS, ordered by signed Q16.16 key then by the smaller count.
// ----------------------------------------------------------------------------
// Sequence: a refused or trivial request goes from lookup straight to the
// result; an insert, removal or change-key first passes a placement, removal
// or change step, and each sift level adds a read and a compare-and-write step.
// Flow: one operation at a time; the next request transfer is taken once the
// result has been posted to the response register.
// Reset: synchronous and active high; it empties the heap at once, through the
// occupancy and the valid bits of the position table, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_min_heap_two_key_core #(
  parameter int MAX_ITEMS = 255
) (
  input logic       clk,
  input logic       rst,
  imh_req_if.sink   req,
  imh_rsp_if.source rsp
);

  // The controller owns sequencing and its state register; the datapath owns every
  // other storage element and evaluates the comparisons that steer each sift step.
  imh_pkg::ucode_t cmd;
  imh_pkg::stat_t  stat;

  imh_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Each sift level has a step that reads the neighbouring slots and a step
  // that compares and writes back the moved entry.
  imh_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule

/* hdl/imh_ctrl.sv */
// ----------------------------------------------------------------------------
// imh_ctrl: operation sequencer
// Walks each operation through lookup, removal or key change, sift up or sift down, and the result.
// ----------------------------------------------------------------------------
module imh_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  imh_pkg::stat_t  stat,
  output imh_pkg::ucode_t cmd
);

  imh_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imh_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = imh_pkg::UC_NONE;
    unique case (state)
      imh_pkg::S_IDLE: begin
        if (stat.req_valid) begin
          cmd        = imh_pkg::UC_LATCH;
          state_next = imh_pkg::S_LOOK;
        end
      end
      imh_pkg::S_LOOK: begin
        state_next = imh_pkg::S_DONE;
        unique case (stat.op)
          imh_pkg::OP_INSERT: begin
            if (!stat.id_ok || stat.present || stat.full) begin
              cmd = imh_pkg::UC_ERR;
            end else begin
              cmd        = imh_pkg::UC_INS;
              state_next = imh_pkg::S_RISE;
            end
          end
          imh_pkg::OP_REMOVE: begin
            if (!stat.present) begin
              cmd = imh_pkg::UC_ERR;
            end else begin
              cmd        = imh_pkg::UC_REM_RD;
              state_next = imh_pkg::S_REM;
            end
          end
          imh_pkg::OP_DELMIN: begin
            if (!stat.empty) begin
              cmd        = imh_pkg::UC_REM_RD;
              state_next = imh_pkg::S_REM;
            end
          end
          imh_pkg::OP_CHANGE: begin
            if (!stat.present) begin
              cmd = imh_pkg::UC_ERR;
            end else begin
              cmd        = imh_pkg::UC_CHG_RD;
              state_next = imh_pkg::S_CHG;
            end
          end
          imh_pkg::OP_CLEAR: cmd = imh_pkg::UC_CLEAR;
          default:           cmd = imh_pkg::UC_ERR;
        endcase
      end
      imh_pkg::S_REM: begin
        cmd = imh_pkg::UC_REM;
        if (stat.rem_same) begin
          state_next = imh_pkg::S_DONE;
        end else if (stat.rem_rise) begin
          state_next = imh_pkg::S_RISE;
        end else begin
          state_next = imh_pkg::S_SINK;
        end
      end
      imh_pkg::S_CHG: begin
        cmd = imh_pkg::UC_CHG;
        if (stat.chg_up) begin
          state_next = imh_pkg::S_RISE;
        end else if (stat.chg_down) begin
          state_next = imh_pkg::S_SINK;
        end else begin
          state_next = imh_pkg::S_DONE;
        end
      end
      imh_pkg::S_RISE: begin
        if (stat.rise_more) begin
          cmd        = imh_pkg::UC_RISE_RD;
          state_next = imh_pkg::S_RISE_CMP;
        end else begin
          cmd        = imh_pkg::UC_PLACE;
          state_next = imh_pkg::S_DONE;
        end
      end
      imh_pkg::S_RISE_CMP: begin
        cmd        = imh_pkg::UC_RISE_STEP;
        state_next = stat.parent_greater ? imh_pkg::S_RISE : imh_pkg::S_DONE;
      end
      imh_pkg::S_SINK: begin
        if (stat.sink_has) begin
          cmd        = imh_pkg::UC_SINK_RD;
          state_next = imh_pkg::S_SINK_CMP;
        end else begin
          cmd        = imh_pkg::UC_PLACE;
          state_next = imh_pkg::S_DONE;
        end
      end
      imh_pkg::S_SINK_CMP: begin
        cmd        = imh_pkg::UC_SINK_STEP;
        state_next = stat.sink_move ? imh_pkg::S_SINK : imh_pkg::S_DONE;
      end
      imh_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd        = imh_pkg::UC_OUT;
          state_next = imh_pkg::S_IDLE;
        end
      end
      default: state_next = imh_pkg::S_IDLE;
    endcase
  end

endmodule

/* hdl/imh_dpath.sv */
// ----------------------------------------------------------------------------
// imh_dpath: heap storage and compare datapath
// Slot memory of entries, position memory with valid bits, and the registers
// for the moving item, the current slot, the occupancy and the result.
// ----------------------------------------------------------------------------
module imh_dpath #(
  parameter int MAX_ITEMS = 255
) (
  input  logic            clk,
  input  logic            rst,
  input  imh_pkg::ucode_t cmd,
  output imh_pkg::stat_t  stat,
  imh_req_if.sink         req,
  imh_rsp_if.source       rsp
);

  localparam int SLOT_W = $clog2(MAX_ITEMS + 1);
  localparam int HEAP_D = 2 ** SLOT_W;
  localparam int POS_D  = 2 ** imh_pkg::ID_W;

  // Strict order on (key, count): signed key first, then unsigned count.
  function automatic logic greater(imh_pkg::entry_t a, imh_pkg::entry_t b);
    logic kg, ke;
    kg = $signed(a.key) > $signed(b.key);
    ke = a.key == b.key;
    return kg || (ke && (a.cnt > b.cnt));
  endfunction

  imh_pkg::entry_t heap_mem [HEAP_D];
  logic [SLOT_W-1:0] pos_mem [POS_D];
  logic [POS_D-1:0]  pos_vld;

  imh_pkg::entry_t   heap_a, heap_b, heap_wd, cur, inp, child;
  logic [SLOT_W-1:0] ra, rb, heap_wa, pos_wd, slot, occ, pos_q, child_slot;
  logic [imh_pkg::ID_W-1:0] pos_ra, pos_wa, pos_ca, found;
  logic              heap_we, pos_we, pos_ce, busy, err, right_ok, sink_has;
  logic [SLOT_W:0]   lchild, rchild;
  imh_pkg::op_t      op;

  assign lchild     = {slot, 1'b0};
  assign rchild     = {slot, 1'b1};
  assign sink_has   = lchild <= {1'b0, occ};
  assign right_ok   = rchild <= {1'b0, occ};
  assign child      = (right_ok && greater(heap_a, heap_b)) ? heap_b : heap_a;
  assign child_slot = (right_ok && greater(heap_a, heap_b)) ? rchild[SLOT_W-1:0]
                                                            : lchild[SLOT_W-1:0];
  assign pos_ra     = req.item_id;

  // Read addresses and write ports.
  always_comb begin
    ra      = '0;
    rb      = '0;
    heap_we = 1'b0;
    heap_wa = slot;
    heap_wd = cur;
    pos_we  = 1'b0;
    pos_wa  = cur.id;
    pos_wd  = slot;
    pos_ce  = 1'b0;
    pos_ca  = heap_a.id;
    case (cmd)
      imh_pkg::UC_REM_RD: begin
        ra = (op == imh_pkg::OP_DELMIN) ? SLOT_W'(1) : pos_q;
        rb = occ;
      end
      imh_pkg::UC_CHG_RD:  ra = pos_q;
      imh_pkg::UC_RISE_RD: ra = slot >> 1;
      imh_pkg::UC_SINK_RD: begin
        ra = lchild[SLOT_W-1:0];
        rb = rchild[SLOT_W-1:0];
      end
      imh_pkg::UC_REM: pos_ce = 1'b1;
      imh_pkg::UC_PLACE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      imh_pkg::UC_RISE_STEP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (greater(heap_a, cur)) begin
          heap_wd = heap_a;
          pos_wa  = heap_a.id;
        end
      end
      imh_pkg::UC_SINK_STEP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (greater(cur, child)) begin
          heap_wd = child;
          pos_wa  = child.id;
        end
      end
      default: ;
    endcase
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    heap_a <= heap_mem[ra];
    heap_b <= heap_mem[rb];
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_q <= pos_vld[pos_ra] ? pos_mem[pos_ra] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd == imh_pkg::UC_CLEAR) begin
      pos_vld <= '0;
    end else begin
      if (pos_we) begin
        pos_vld[pos_wa] <= 1'b1;
      end
      if (pos_ce) begin
        pos_vld[pos_ca] <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd)
      imh_pkg::UC_LATCH: begin
        op      <= imh_pkg::op_t'(req.operation);
        inp.id  <= req.item_id;
        inp.key <= req.key_value;
        inp.cnt <= req.count_value;
      end
      imh_pkg::UC_INS: begin
        cur  <= inp;
        slot <= occ + SLOT_W'(1);
      end
      imh_pkg::UC_REM_RD:  slot <= ra;
      imh_pkg::UC_CHG_RD:  slot <= pos_q;
      imh_pkg::UC_REM:     cur  <= heap_b;
      imh_pkg::UC_CHG:     cur  <= inp;
      imh_pkg::UC_RISE_STEP: begin
        if (greater(heap_a, cur)) begin
          slot <= slot >> 1;
        end
      end
      imh_pkg::UC_SINK_STEP: begin
        if (greater(cur, child)) begin
          slot <= child_slot;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      busy      <= 1'b0;
      err       <= 1'b0;
      found     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (cmd)
        imh_pkg::UC_LATCH: begin
          busy  <= 1'b1;
          err   <= 1'b0;
          found <= '0;
        end
        imh_pkg::UC_ERR:   err <= 1'b1;
        imh_pkg::UC_INS:   occ <= occ + SLOT_W'(1);
        imh_pkg::UC_CLEAR: occ <= '0;
        imh_pkg::UC_REM: begin
          occ <= occ - SLOT_W'(1);
          if (op == imh_pkg::OP_DELMIN) begin
            found <= heap_a.id;
          end
        end
        imh_pkg::UC_OUT: begin
          busy          <= 1'b0;
          rsp.valid     <= 1'b1;
          rsp.min_item  <= found;
          rsp.heap_size <= imh_pkg::SIZE_W'(occ);
          rsp.error     <= err;
        end
        default: ;
      endcase
    end
  end

  assign req.ready = !busy;

  always_comb begin
    stat.req_valid      = req.valid;
    stat.op             = op;
    stat.id_ok          = (inp.id != '0) && (32'(inp.id) <= MAX_ITEMS);
    stat.present        = stat.id_ok && (pos_q != '0);
    stat.full           = 32'(occ) >= MAX_ITEMS;
    stat.empty          = occ == '0;
    stat.rem_same       = slot == occ;
    stat.rem_rise       = !greater(heap_b, heap_a);
    stat.chg_up         = greater(heap_a, inp);
    stat.chg_down       = greater(inp, heap_a);
    stat.rise_more      = slot > SLOT_W'(1);
    stat.parent_greater = greater(heap_a, cur);
    stat.sink_has       = sink_has;
    stat.sink_move      = greater(cur, child);
    stat.out_free       = !rsp.valid || rsp.ready;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= MAX_ITEMS) else $error("occupancy above capacity");
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd == imh_pkg::UC_CLEAR |=> occ == '0) else $error("clear left items");
  a_place_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd == imh_pkg::UC_PLACE || cmd == imh_pkg::UC_RISE_STEP ||
     cmd == imh_pkg::UC_SINK_STEP) |-> slot != '0) else $error("write to slot zero");
  a_busy_ready: assert property (@(posedge clk) disable iff (rst)
    cmd == imh_pkg::UC_OUT |=> !busy && rsp.valid) else $error("result not posted");

endmodule
